[rtl/hrhs_pkg.sv]
// shared types, codes and constant tables for the http response header stripper
package hrhs_pkg;

  // parse phase
  typedef enum logic [2:0] {
    PH_STATUS = 3'd0,
    PH_NAME   = 3'd1,
    PH_CR     = 3'd2,
    PH_SKIPSP = 3'd3,
    PH_VALUE  = 3'd4,
    PH_VEND   = 3'd5,
    PH_BODY   = 3'd6,
    PH_DEAD   = 3'd7
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_BODY  = 2'd1;
  localparam logic [1:0] KIND_IMAGE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SLEEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STATUS    = 1'd1;
  localparam int unsigned CFG_DATA_W = 32;

  // field widths
  localparam int unsigned SLEEP_W  = 31;
  localparam int unsigned STATUS_W = 10;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned POS_W    = 8;

  // reset values and limits
  localparam logic [SLEEP_W-1:0]  SLEEP_RESET  = 31'd600000;
  localparam logic [STATUS_W-1:0] STATUS_RESET = 10'd302;
  localparam logic [SLEEP_W-1:0]  SLEEP_MAX    = {SLEEP_W{1'b1}};
  localparam logic [STATUS_W-1:0] STATUS_MAX   = {STATUS_W{1'b1}};
  localparam logic [POS_W-1:0]    POS_MAX      = {POS_W{1'b1}};
  localparam logic [POS_W-1:0]    PREFIX_LEN   = 8'd7;
  localparam logic [POS_W-1:0]    STATUS_OFS   = 8'd9;
  localparam logic [POS_W-1:0]    MIN_STATUS_LEN = 8'd12;
  localparam logic [POS_W-1:0]    NAME_LEN     = 8'd17;

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] IMAGE_MARK = 8'h40;
  localparam logic [7:0] CONNECT_ERR = 8'h06;

  // status line prefix "HTTP/1."
  localparam logic [7:0] PROTO_PREFIX [7] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E
  };

  // header name "Sleep-Duration-Ms"
  localparam logic [7:0] SLEEP_NAME [17] = '{
    8'h53, 8'h6C, 8'h65, 8'h65, 8'h70, 8'h2D, 8'h44, 8'h75, 8'h72,
    8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h2D, 8'h4D, 8'h73
  };

  // one input item held between stages
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_chunk;
  } item_t;

endpackage

[rtl/hrhs_if.sv]
// valid/ready channel interfaces for input items, result items and config writes
interface hrhs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_chunk;

  modport source (output valid, output data_byte, output last_in_chunk, input ready);
  modport sink   (input valid, input data_byte, input last_in_chunk, output ready);
endinterface

interface hrhs_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    out_kind;
  logic [7:0]                    out_byte;
  logic                          out_last;
  logic [hrhs_pkg::SLEEP_W-1:0]  sleep_ms;
  logic [hrhs_pkg::COUNT_W-1:0]  body_count;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  output sleep_ms, output body_count, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  input sleep_ms, input body_count, output ready);
endinterface

interface hrhs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hrhs_pkg::CFG_IDX_W-1:0]  index;
  logic [hrhs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/hrhs_in_stage.sv]
// input register holding one received item ahead of the parser
module hrhs_in_stage (
  input  logic            clk,
  input  logic            rst,
  hrhs_in_if.sink         rx,
  output logic            vld,
  output hrhs_pkg::item_t item,
  input  logic            take
);
  import hrhs_pkg::*;

  // free slot or slot drained this cycle
  assign rx.ready = !vld || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.data_byte     <= rx.data_byte;
      item.last_in_chunk <= rx.last_in_chunk;
    end
  end

endmodule

[rtl/hrhs_parser.sv]
// parse state, per-byte step logic and result register
module hrhs_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  hrhs_pkg::item_t item,
  output logic            take,
  hrhs_cfg_if.sink        cfg,
  hrhs_out_if.source      tx
);
  import hrhs_pkg::*;

  typedef struct packed {
    phase_t           phase;
    logic [POS_W-1:0] pos;
    logic             match;
  } name_res_t;

  phase_t               phase, phase_next;
  logic [POS_W-1:0]     line_pos, line_pos_next;
  logic                 prefix_ok, prefix_ok_next;
  logic [STATUS_W-1:0]  status_acc, status_acc_next;
  logic                 digits_done, digits_done_next;
  logic                 name_match, name_match_next;
  logic [SLEEP_W-1:0]   value_acc, value_acc_next;
  logic [SLEEP_W-1:0]   sleep_value, sleep_value_next;
  logic [COUNT_W-1:0]   sent_count, sent_count_next;
  logic [STATUS_W-1:0]  max_status;

  logic [7:0]           b;
  logic                 is_dig;
  logic [3:0]           dig;
  logic [13:0]          status_x10;
  logic [34:0]          value_x10;
  logic [STATUS_W-1:0]  status_sat;
  logic [SLEEP_W-1:0]   value_sat;
  logic                 status_fail;
  logic [1:0]           kind;
  logic [7:0]           obyte;
  name_res_t            nr_line, nr_cr;

  // one header-name byte
  function automatic name_res_t name_step(input logic [POS_W-1:0] pos,
                                          input logic match, input logic [7:0] c);
    name_res_t r;
    r.phase = PH_NAME;
    r.pos   = pos;
    r.match = match;
    if (c == CH_COLON) begin
      r.match = match && (pos == NAME_LEN);
      r.phase = PH_SKIPSP;
    end else begin
      if (pos >= NAME_LEN) begin
        r.match = 1'b0;
      end else if (c != SLEEP_NAME[pos[4:0]]) begin
        r.match = 1'b0;
      end
      if (pos != POS_MAX) r.pos = pos + 1'b1;
    end
    return r;
  endfunction

  assign take = in_vld && (!tx.valid || tx.ready);
  assign cfg.ready = 1'b1;
  assign b = item.data_byte;

  // digit decode and saturating times-ten accumulators
  assign is_dig     = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dig        = b[3:0];
  assign status_x10 = ({4'b0, status_acc} << 3) + ({4'b0, status_acc} << 1) + 14'(dig);
  assign status_sat = (status_x10 > 14'(STATUS_MAX)) ? STATUS_MAX : status_x10[STATUS_W-1:0];
  assign value_x10  = ({4'b0, value_acc} << 3) + ({4'b0, value_acc} << 1) + 35'(dig);
  assign value_sat  = (value_x10 > 35'(SLEEP_MAX)) ? SLEEP_MAX : value_x10[SLEEP_W-1:0];
  assign status_fail = !prefix_ok || (line_pos < MIN_STATUS_LEN) || (status_acc > max_status);
  assign nr_line = name_step(line_pos, name_match, b);
  assign nr_cr   = name_step(8'd1, 1'b0, b);

  // next parse state
  always_comb begin
    phase_next       = phase;
    line_pos_next    = line_pos;
    prefix_ok_next   = prefix_ok;
    status_acc_next  = status_acc;
    digits_done_next = digits_done;
    name_match_next  = name_match;
    value_acc_next   = value_acc;
    sleep_value_next = sleep_value;
    sent_count_next  = sent_count;
    unique case (phase)
      PH_STATUS: begin
        if (b == CH_LF) begin
          if (status_fail) begin
            phase_next = PH_DEAD;
          end else begin
            phase_next      = PH_NAME;
            line_pos_next   = '0;
            name_match_next = 1'b1;
            value_acc_next  = '0;
          end
        end else begin
          if (line_pos < PREFIX_LEN && b != PROTO_PREFIX[line_pos[2:0]]) begin
            prefix_ok_next = 1'b0;
          end
          if (line_pos >= STATUS_OFS && !digits_done) begin
            if (is_dig) status_acc_next = status_sat;
            else digits_done_next = 1'b1;
          end
          if (line_pos != POS_MAX) line_pos_next = line_pos + 1'b1;
        end
      end
      PH_NAME: begin
        if (line_pos == '0 && b == CH_CR) begin
          phase_next = PH_CR;
        end else begin
          phase_next      = nr_line.phase;
          line_pos_next   = nr_line.pos;
          name_match_next = nr_line.match;
        end
      end
      PH_CR: begin
        if (b == CH_LF) begin
          phase_next = PH_BODY;
        end else begin
          phase_next      = nr_cr.phase;
          line_pos_next   = nr_cr.pos;
          name_match_next = nr_cr.match;
        end
      end
      PH_SKIPSP, PH_VALUE, PH_VEND: begin
        if (phase == PH_SKIPSP && b == CH_SP) begin
          phase_next = phase;
        end else if (b == CH_LF) begin
          if (name_match) sleep_value_next = value_acc;
          phase_next      = PH_NAME;
          line_pos_next   = '0;
          name_match_next = 1'b1;
          value_acc_next  = '0;
        end else if (phase != PH_VEND && is_dig) begin
          phase_next     = PH_VALUE;
          value_acc_next = value_sat;
        end else begin
          phase_next = PH_VEND;
        end
      end
      PH_BODY: begin
        sent_count_next = sent_count + 1'b1;
      end
      PH_DEAD: begin
        phase_next = PH_DEAD;
      end
      default: begin
        phase_next = PH_DEAD;
      end
    endcase
  end

  // result for this byte
  always_comb begin
    kind  = KIND_NONE;
    obyte = 8'h00;
    unique case (phase)
      PH_STATUS: begin
        if (b == CH_LF && status_fail) begin
          kind  = KIND_ERROR;
          obyte = CONNECT_ERR;
        end
      end
      PH_CR: begin
        if (b == CH_LF) begin
          kind  = KIND_IMAGE;
          obyte = IMAGE_MARK;
        end
      end
      PH_BODY: begin
        kind  = KIND_BODY;
        obyte = b;
      end
      default: begin
        kind  = KIND_NONE;
        obyte = 8'h00;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STATUS;
      line_pos    <= '0;
      prefix_ok   <= 1'b1;
      status_acc  <= '0;
      digits_done <= 1'b0;
      name_match  <= 1'b1;
      value_acc   <= '0;
      sleep_value <= SLEEP_RESET;
      sent_count  <= '0;
      max_status  <= STATUS_RESET;
    end else begin
      if (take) begin
        phase       <= phase_next;
        line_pos    <= line_pos_next;
        prefix_ok   <= prefix_ok_next;
        status_acc  <= status_acc_next;
        digits_done <= digits_done_next;
        name_match  <= name_match_next;
        value_acc   <= value_acc_next;
        sleep_value <= sleep_value_next;
        sent_count  <= sent_count_next;
      end
      // the user must make register writes only while idle; the block itself does not enforce it
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_DEFAULT_SLEEP) sleep_value <= cfg.data[SLEEP_W-1:0];
        if (cfg.index == CFG_MAX_STATUS) max_status <= cfg.data[STATUS_W-1:0];
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (take) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      tx.out_kind   <= kind;
      tx.out_byte   <= obyte;
      tx.out_last   <= item.last_in_chunk;
      tx.sleep_ms   <= sleep_value_next;
      tx.body_count <= sent_count_next;
    end
  end

endmodule

[rtl/http_response_header_stripper.sv]
// an accepted byte passes through the input register, then its result item is held in the result register
// throughput: one byte per cycle while the result channel is not stalled by tx.ready
// the input register and the result register each hold one item
// reset (rst, synchronous): status-line parse, sleep duration 600000, status limit 302
// body byte count cleared; no clearing pass, items are accepted right after reset
module http_response_header_stripper (
  input  logic       clk,
  input  logic       rst,
  hrhs_in_if.sink    rx,
  hrhs_cfg_if.sink   cfg,
  hrhs_out_if.source tx
);
  import hrhs_pkg::*;

  logic  stage_vld;
  item_t stage_item;
  logic  stage_take;

  // input register
  hrhs_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .vld  (stage_vld),
    .item (stage_item),
    .take (stage_take)
  );

  // parser and result register
  hrhs_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .in_vld (stage_vld),
    .item   (stage_item),
    .take   (stage_take),
    .cfg    (cfg),
    .tx     (tx)
  );

endmodule

[tb/sv/tb.sv]
// testbench for the http response header stripper: directed and random response streams against a parser model
module tb;
  import hrhs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int STATUS_LOW     = 100;
  localparam int STATUS_HIGH    = 999;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic               last;
    logic [SLEEP_W-1:0] sleep;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrhs_in_if  rx_if ();
  hrhs_cfg_if cfg_if ();
  hrhs_out_if tx_if ();

  http_response_header_stripper dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .cfg(cfg_if),
    .tx(tx_if)
  );

  always #4 clk = ~clk;

  item_t       in_bytes [$];
  out_item_t   expected_outputs [$];
  int unsigned bytes_queued   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned outputs_seen   = 0;
  int unsigned quiet_cycles   = 0;

  // parser model state, at its reset values
  phase_t              ph         = PH_STATUS;
  logic [POS_W-1:0]    pos        = '0;
  logic                prefix_ok  = 1'b1;
  logic [STATUS_W-1:0] status_acc = '0;
  logic                status_end = 1'b0;
  logic                name_hit   = 1'b1;
  logic [SLEEP_W-1:0]  value_acc  = '0;
  logic [SLEEP_W-1:0]  sleep_val  = SLEEP_RESET;
  logic [COUNT_W-1:0]  body_cnt   = '0;
  logic [STATUS_W-1:0] max_status = STATUS_RESET;

  function automatic logic is_dec(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic void start_line();
    ph        = PH_NAME;
    pos       = '0;
    name_hit  = 1'b1;
    value_acc = '0;
  endfunction

  // header name byte: compare against the sleep header name up to the colon
  function automatic void name_char(logic [7:0] b);
    if (b == CH_COLON) begin
      name_hit = name_hit && (pos == NAME_LEN);
      ph = PH_SKIPSP;
    end else begin
      if (pos >= NAME_LEN || b != SLEEP_NAME[pos[4:0]]) name_hit = 1'b0;
      if (pos != POS_MAX) pos = pos + 1'b1;
    end
  endfunction

  // header value byte: leading digits accumulate, saturating at 31 bits
  function automatic void value_char(logic [7:0] b);
    longint unsigned v;
    if (b == CH_LF) begin
      if (name_hit) sleep_val = value_acc;
      start_line();
    end else if (ph == PH_VALUE && is_dec(b)) begin
      v = longint'(value_acc) * 10 + (b - CH_ZERO);
      value_acc = (v > SLEEP_MAX) ? SLEEP_MAX : v[SLEEP_W-1:0];
    end else begin
      ph = PH_VEND;
    end
  endfunction

  // advance the model by one byte and queue the output item it causes
  function automatic void parse_byte(logic [7:0] b, logic last);
    out_item_t   r;
    int unsigned code;
    r = '0;
    r.kind = KIND_NONE;
    r.last = last;
    case (ph)
      PH_STATUS: begin
        if (b == CH_LF) begin
          if (!prefix_ok || pos < MIN_STATUS_LEN || status_acc > max_status) begin
            r.kind = KIND_ERROR;
            r.data = CONNECT_ERR;
            ph = PH_DEAD;
          end else begin
            start_line();
          end
        end else begin
          if (pos < PREFIX_LEN && b != PROTO_PREFIX[pos[2:0]]) prefix_ok = 1'b0;
          if (pos >= STATUS_OFS && !status_end) begin
            if (is_dec(b)) begin
              code = status_acc * 10 + (b - CH_ZERO);
              status_acc = (code > STATUS_MAX) ? STATUS_MAX : code[STATUS_W-1:0];
            end else begin
              status_end = 1'b1;
            end
          end
          if (pos != POS_MAX) pos = pos + 1'b1;
        end
      end
      PH_NAME: begin
        if (pos == 0 && b == CH_CR) ph = PH_CR;
        else name_char(b);
      end
      PH_CR: begin
        if (b == CH_LF) begin
          r.kind = KIND_IMAGE;
          r.data = IMAGE_MARK;
          ph = PH_BODY;
        end else begin
          // lone cr: the line becomes a non-matching name
          ph = PH_NAME;
          name_hit = 1'b0;
          pos = 8'd1;
          name_char(b);
        end
      end
      PH_SKIPSP: begin
        if (b != CH_SP) begin
          ph = PH_VALUE;
          value_char(b);
        end
      end
      PH_VALUE, PH_VEND: value_char(b);
      PH_BODY: begin
        r.kind = KIND_BODY;
        r.data = b;
        body_cnt = body_cnt + 1'b1;
      end
      default: ;
    endcase
    r.sleep = sleep_val;
    r.count = body_cnt;
    expected_outputs.push_back(r);
  endfunction

  // input driver
  always @(posedge clk) begin
    item_t nxt;
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) parse_byte(rx_if.data_byte, rx_if.last_in_chunk);
      if (!rx_if.valid || rx_if.ready) begin
        if (in_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = in_bytes.pop_front();
          rx_if.valid         <= 1'b1;
          rx_if.data_byte     <= nxt.data_byte;
          rx_if.last_in_chunk <= nxt.last_in_chunk;
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst) begin
      tx_if.ready <= 1'b0;
    end else begin
      if (tx_if.valid && tx_if.ready) begin
        got.kind  = tx_if.out_kind;
        got.data  = tx_if.out_byte;
        got.last  = tx_if.out_last;
        got.sleep = tx_if.sleep_ms;
        got.count = tx_if.body_count;
        outputs_seen++;
        if (expected_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("output item %0d not expected: kind %0d byte %h", outputs_seen,
                     got.kind, got.data);
        end else begin
          want = expected_outputs.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last ||
              got.sleep !== want.sleep || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"output item %0d mismatch: expected kind %0d byte %h last %0b ",
                        "sleep %0d count %0d, got kind %0d byte %h last %0b sleep %0d count %0d"},
                       outputs_seen, want.kind, want.data, want.last, want.sleep, want.count,
                       got.kind, got.data, got.last, got.sleep, got.count);
          end
        end
      end
      tx_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** http_response_header_stripper: FAILED **");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b);
    item_t it;
    it.data_byte     = b;
    it.last_in_chunk = ($urandom_range(7) == 0);
    in_bytes.push_back(it);
    bytes_queued++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic end_line();
    if ($urandom_range(1) == 0) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  // one random header line
  task automatic push_header_line();
    int         sel;
    int         k;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 40) begin
      // the sleep header with a random value, often past the 31-bit limit
      push_text("Sleep-Duration-Ms:");
      repeat ($urandom_range(3)) push_byte(CH_SP);
      repeat ($urandom_range(12)) push_byte(CH_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(3) == 0) push_text(" ms");
    end else if (sel < 55) begin
      // near misses of the sleep header name
      case ($urandom_range(2))
        0: begin
          k = $urandom_range(NAME_LEN - 1);
          for (int i = 0; i < NAME_LEN; i++)
            push_byte(i == k ? SLEEP_NAME[i] ^ 8'h20 : SLEEP_NAME[i]);
        end
        1: push_text("Sleep-Duration-Mss");
        default: push_text("Sleep-Duration-M");
      endcase
      push_text(": ");
      repeat ($urandom_range(6, 1)) push_byte(CH_ZERO + 8'($urandom_range(9)));
    end else if (sel < 80) begin
      // ordinary header
      repeat ($urandom_range(16, 1)) push_byte(8'h61 + 8'($urandom_range(25)));
      push_text(": ");
      repeat ($urandom_range(20)) push_byte(8'($urandom_range(8'h7E, 8'h20)));
    end else if (sel < 95) begin
      // noise bytes, no line breaks inside
      repeat ($urandom_range(30, 1)) begin
        b = 8'($urandom_range(255));
        if (b == CH_CR || b == CH_LF) b = b ^ 8'h80;
        push_byte(b);
      end
    end else if (sel < 98) begin
      // lone cr at the start of a line
      push_byte(CH_CR);
      push_byte(8'h41 + 8'($urandom_range(25)));
      push_text(": 1");
    end else begin
      // name longer than the position counter
      repeat (270) push_byte(8'h61 + 8'($urandom_range(25)));
      push_text(": 5");
    end
    end_line();
  endtask

  // wait until every queued item went in and every output item came back
  task automatic wait_idle();
    do @(negedge clk);
    while (in_bytes.size() != 0 || rx_if.valid || expected_outputs.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_DEFAULT_SLEEP) sleep_val = value[SLEEP_W-1:0];
    else max_status = value[STATUS_W-1:0];
  endtask

  // stimulus sequence
  initial begin
    string directed [] = '{
      "Content-Type: image/bmp",
      "Sleep-Duration-Ms: 1234",
      "Sleep-Duration-Ms:99999999999999",
      "Sleep-Duration-Ms:   abc",
      "Sleep-Duration-Ms: 2147483647",
      "Sleep-Duration-Ms:",
      "sleep-duration-ms: 55",
      "Sleep-Duration-Msx: 7",
      "Sleep-Duration-M: 7",
      "Sleep-Duration-Ms :5",
      "Sleep-Duration-Ms: 42 ms 77",
      "Sleep-Duration-Ms: 4294967296",
      "Sleep-Duration-Ms: 000",
      "Sleep-Duration-Ms: 600"
    };
    string       s;
    int unsigned limit;
    int          k;

    rx_if.valid         = 1'b0;
    rx_if.data_byte     = '0;
    rx_if.last_in_chunk = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    tx_if.ready         = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // status limit: reset value, an extreme or a random point
    case ($urandom_range(3))
      0: limit = 32'(STATUS_RESET);
      1: limit = STATUS_LOW;
      2: limit = STATUS_HIGH;
      default: limit = $urandom_range(STATUS_HIGH, STATUS_LOW);
    endcase
    if (limit != STATUS_RESET) write_reg(CFG_MAX_STATUS, limit);

    // status line, mostly well formed
    if ($urandom_range(7) != 0) begin
      case ($urandom_range(4))
        0: begin
          push_text($sformatf("HTTP/1.1 %0d OK", limit));
          end_line();
        end
        1: begin
          push_text($sformatf("HTTP/1.%0d %03d Fine", $urandom_range(9), $urandom_range(limit)));
          end_line();
        end
        2: begin
          // shortest accepted line
          push_text($sformatf("HTTP/1.0 %0d", $urandom_range(limit, STATUS_LOW)));
          push_byte(CH_LF);
        end
        3: begin
          // no digits gives code zero
          push_text("HTTP/1.1 Found");
          end_line();
        end
        default: begin
          push_text("HTTP/1.1 100 ");
          repeat (280) push_byte(8'h61 + 8'($urandom_range(25)));
          end_line();
        end
      endcase
    end else begin
      case ($urandom_range(3))
        0: begin
          push_text($sformatf("HTTP/1.1 %0d Over", limit + 1));
          end_line();
        end
        1: begin
          // code saturates
          push_text("HTTP/1.1 99999 OK");
          end_line();
        end
        2: begin
          // one byte too short
          push_text("HTTP/1.1 20");
          push_byte(CH_LF);
        end
        default: begin
          s = "HTTP/1.1 100 OK";
          k = $urandom_range(PREFIX_LEN - 1);
          for (int i = 0; i < s.len(); i++) push_byte(i == k ? s[i] ^ 8'h01 : s[i]);
          end_line();
        end
      endcase
    end

    // directed header lines
    foreach (directed[i]) begin
      push_text(directed[i]);
      end_line();
    end
    push_byte(CH_CR);
    push_text("X-Lone: 9");
    end_line();
    push_byte(CH_CR);
    push_text("Sleep-Duration-Ms: 8");
    end_line();
    push_text("Na");
    push_byte(CH_LF);
    push_text("me: 3");
    end_line();
    wait_idle();
    write_reg(CFG_DEFAULT_SLEEP, CFG_DATA_W'(SLEEP_MAX));

    // random headers, sender idling
    send_idle_pct = 52;
    while (bytes_queued < 700) push_header_line();
    wait_idle();
    write_reg(CFG_DEFAULT_SLEEP, '0);
    write_reg(CFG_MAX_STATUS, STATUS_HIGH);

    // more headers, then the blank line and body bytes, receiver stalling
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    while (bytes_queued < 1100) push_header_line();
    // close whatever line is open before the blank line
    push_text("z:");
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    repeat (150) push_byte(8'($urandom_range(255)));
    // sender holds until every output item is back
    wait_idle();
    repeat (200) push_byte(8'($urandom_range(255)));
    wait_idle();
    write_reg(CFG_DEFAULT_SLEEP, $urandom() >> 1);
    write_reg(CFG_MAX_STATUS, STATUS_LOW);

    // body bytes, both sides idling
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    while (bytes_queued < 1900) push_byte(8'($urandom_range(255)));
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_outputs.size() == 0)
      $display("** http_response_header_stripper: PASSED **");
    else
      $display("** http_response_header_stripper: FAILED **");
    $finish;
  end

endmodule
